### sv/dwm_pkg.sv
package dwm_pkg;

  localparam int CMD_W       = 16;
  localparam int SUM_W       = CMD_W + 1;
  localparam int WHL_W       = 11;
  localparam int DB_W        = 10;
  localparam int WHEEL_LIMIT = 1000;
  localparam int DIV_BITS    = 10;
  localparam int REM_W       = 26;
  localparam int NSTG        = DIV_BITS + 3;

  typedef struct packed {
    logic                    direct;
    logic                    scale;
    logic signed [SUM_W-1:0] lraw;
    logic signed [SUM_W-1:0] rraw;
    logic                    lsign;
    logic                    rsign;
    logic [SUM_W-1:0]        divisor;
    logic [REM_W-1:0]        lrem;
    logic [REM_W-1:0]        rrem;
    logic [DIV_BITS-1:0]     lquo;
    logic [DIV_BITS-1:0]     rquo;
  } work_t;

endpackage

### sv/differential_wheel_mixer.sv
// Channel   Direction  Handshake            Payload
// in        in         in_valid / in_stall  func, first_cmd, second_cmd
// out       out        out_valid/ out_stall left_cmd, right_cmd
// cfg       in         cfg_wr_en            cfg_wr_data (deadband)
//
// A request can enter every cycle while in_stall is low. The stages are: mix,
// magnitude and multiply by the wheel limit, ten restoring-division stages (one
// quotient bit each), then clamp and deadband into the output register.
// rst clears all stage valid bits and the deadband register.
// Each stage advances when its successor is empty or advancing, so bubbles
// collapse and a stalled output holds without loss.
module differential_wheel_mixer
  import dwm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    func,
  input  logic signed [CMD_W-1:0] first_cmd,
  input  logic signed [CMD_W-1:0] second_cmd,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [WHL_W-1:0] left_cmd,
  output logic signed [WHL_W-1:0] right_cmd,
  input  logic                    cfg_wr_en,
  input  logic [DB_W-1:0]         cfg_wr_data
);

  logic [DB_W-1:0] deadband;
  logic [NSTG-1:0] valid;
  logic [NSTG-1:0] ready;
  work_t           pipe [NSTG-1];
  work_t           mix_next;
  work_t           scale_next;
  work_t           div_next [DIV_BITS];
  logic signed [WHL_W-1:0] left_next;
  logic signed [WHL_W-1:0] right_next;

  function automatic work_t div_step(work_t w, int unsigned sh);
    logic [REM_W-1:0] dsh;
    logic [REM_W:0]   lt;
    logic [REM_W:0]   rt;
    work_t            o;
    o   = w;
    dsh = REM_W'(w.divisor) << sh;
    lt  = {1'b0, w.lrem} - {1'b0, dsh};
    rt  = {1'b0, w.rrem} - {1'b0, dsh};
    if (!lt[REM_W]) begin
      o.lrem = lt[REM_W-1:0];
    end
    if (!rt[REM_W]) begin
      o.rrem = rt[REM_W-1:0];
    end
    o.lquo = {w.lquo[DIV_BITS-2:0], ~lt[REM_W]};
    o.rquo = {w.rquo[DIV_BITS-2:0], ~rt[REM_W]};
    return o;
  endfunction

  function automatic logic signed [WHL_W-1:0] finish_wheel(
    logic signed [SUM_W-1:0] raw,
    logic                    scale,
    logic                    sign,
    logic [DIV_BITS-1:0]     quo,
    logic [DB_W-1:0]         db
  );
    logic signed [WHL_W-1:0] c;
    logic [WHL_W-1:0]        m;
    if (scale) begin
      c = sign ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end else if (raw > SUM_W'(WHEEL_LIMIT)) begin
      c = WHL_W'(WHEEL_LIMIT);
    end else if (raw < -SUM_W'(WHEEL_LIMIT)) begin
      c = -WHL_W'(WHEEL_LIMIT);
    end else begin
      c = raw[WHL_W-1:0];
    end
    m = c[WHL_W-1] ? WHL_W'(-c) : WHL_W'(c);
    return (m < {1'b0, db}) ? '0 : c;
  endfunction

  // handshake: a stage takes new data when empty or when it moves on
  always_comb begin
    ready[NSTG-1] = !valid[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  assign in_stall  = rst || !ready[0];
  assign out_valid = valid[NSTG-1];

  // mix stage
  always_comb begin
    mix_next        = '0;
    mix_next.direct = func;
    if (func) begin
      mix_next.lraw = SUM_W'(first_cmd);
      mix_next.rraw = SUM_W'(second_cmd);
    end else begin
      mix_next.lraw = SUM_W'(first_cmd) + SUM_W'(second_cmd);
      mix_next.rraw = SUM_W'(first_cmd) - SUM_W'(second_cmd);
    end
  end

  // magnitude, scale decision, dividend = magnitude * limit
  always_comb begin
    logic [SUM_W-1:0] lmag;
    logic [SUM_W-1:0] rmag;
    logic [SUM_W-1:0] big;
    scale_next       = pipe[0];
    lmag             = pipe[0].lraw[SUM_W-1] ? SUM_W'(-pipe[0].lraw) : SUM_W'(pipe[0].lraw);
    rmag             = pipe[0].rraw[SUM_W-1] ? SUM_W'(-pipe[0].rraw) : SUM_W'(pipe[0].rraw);
    big              = (lmag > rmag) ? lmag : rmag;
    scale_next.scale = !pipe[0].direct && (big > SUM_W'(WHEEL_LIMIT));
    scale_next.lsign = pipe[0].lraw[SUM_W-1];
    scale_next.rsign = pipe[0].rraw[SUM_W-1];
    scale_next.divisor = big;
    scale_next.lrem  = REM_W'(lmag) * REM_W'(WHEEL_LIMIT);
    scale_next.rrem  = REM_W'(rmag) * REM_W'(WHEEL_LIMIT);
    scale_next.lquo  = '0;
    scale_next.rquo  = '0;
  end

  // one quotient bit per stage, most significant first
  always_comb begin
    for (int k = 0; k < DIV_BITS; k++) begin
      div_next[k] = div_step(pipe[k+1], DIV_BITS - 1 - k);
    end
  end

  always_comb begin
    left_next  = finish_wheel(pipe[NSTG-2].lraw, pipe[NSTG-2].scale, pipe[NSTG-2].lsign,
                              pipe[NSTG-2].lquo, deadband);
    right_next = finish_wheel(pipe[NSTG-2].rraw, pipe[NSTG-2].scale, pipe[NSTG-2].rsign,
                              pipe[NSTG-2].rquo, deadband);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      deadband <= '0;
    end else begin
      if (cfg_wr_en) begin
        deadband <= cfg_wr_data;
      end
      if (ready[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (ready[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0] && in_valid) begin
      pipe[0] <= mix_next;
    end
    if (ready[1] && valid[0]) begin
      pipe[1] <= scale_next;
    end
    for (int k = 0; k < DIV_BITS; k++) begin
      if (ready[k+2] && valid[k+1]) begin
        pipe[k+2] <= div_next[k];
      end
    end
    if (ready[NSTG-1] && valid[NSTG-2]) begin
      left_cmd  <= left_next;
      right_cmd <= right_next;
    end
  end

endmodule
